FILE: rtl/ffxd_pkg.sv
// Package for the form field extract/decode block: word types, result codes,
// register indexes and byte constants. No dependencies.
`default_nettype none

package ffxd_pkg;

    typedef struct packed {
        logic [7:0] body_byte;
        logic       body_end;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        data_valid;
        logic        final_flag;
        logic [1:0]  status;
        logic [15:0] value_length;
    } out_item_t;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 64;

    localparam logic [CFG_INDEX_BITS-1:0] REG_KEY_LOW    = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_KEY_HIGH   = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_KEY_COUNT  = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CAPACITY   = 2'd3;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND  = 2'd1;
    localparam logic [1:0] ST_BAD_ESCAPE = 2'd2;
    localparam logic [1:0] ST_OVERFLOW   = 2'd3;

    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_EQUAL   = 8'h3D;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    localparam logic [4:0]  KEY_COUNT_RESET = 5'd1;
    localparam logic [15:0] CAPACITY_RESET  = 16'd64;

    // {valid, nibble}
    function automatic logic [4:0] hex_digit_decode(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, 4'(b - 8'h30)};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            r = {1'b1, 4'(b - 8'h57)};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            r = {1'b1, 4'(b - 8'h37)};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/form_field_extract_decode_top.sv
// Streaming urlencoded form field extractor and percent decoder.
// Depends on ffxd_pkg.
`default_nettype none

// One body byte per clock. A byte is taken into an input register, then
// decoded combinationally into zero, one or two result words that go into
// a four-word result queue driving the m_ port. The first result word shows
// on the m_ port after the input register and the queue. The decode stage
// waits only while the queue holds more than two words, so the rate is set
// by the result side: at full output readiness a byte is taken every cycle,
// and the closing byte of a body, which can give two words, still fits.
// Configuration writes take effect at once and are meant for idle periods
// between bodies.
module form_field_extract_decode_top #(
    parameter int MAX_KEY_CHARS = 16,
    parameter int LENGTH_BITS   = 16
) (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    input  wire                                   s_valid,
    output logic                                  s_ready,
    input  wire  ffxd_pkg::in_item_t              s_item,
    output logic                                  m_valid,
    input  wire                                   m_ready,
    output ffxd_pkg::out_item_t                   m_item,
    input  wire                                   cfg_wr_en,
    input  wire  [ffxd_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  wire  [ffxd_pkg::CFG_DATA_BITS-1:0]    cfg_wr_data
);

    typedef enum logic [3:0] {
        PH_NAME  = 4'b0001,
        PH_VALUE = 4'b0010,
        PH_DONE  = 4'b0100,
        PH_SKIP  = 4'b1000
    } phase_t;

    typedef enum logic [2:0] {
        ESC_NONE = 3'b001,
        ESC_HIGH = 3'b010,
        ESC_LOW  = 3'b100
    } esc_t;

    localparam int QDEPTH = 4;
    localparam int QPTR   = 2;
    localparam logic [LENGTH_BITS-1:0] LEN_LIMIT = {LENGTH_BITS{1'b1}};

    // configuration
    logic [63:0] key_low_reg, key_high_reg;
    logic [4:0]  key_count_reg;
    logic [15:0] capacity_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_low_reg   <= '0;
            key_high_reg  <= '0;
            key_count_reg <= ffxd_pkg::KEY_COUNT_RESET;
            capacity_reg  <= ffxd_pkg::CAPACITY_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                ffxd_pkg::REG_KEY_LOW:   key_low_reg   <= cfg_wr_data;
                ffxd_pkg::REG_KEY_HIGH:  key_high_reg  <= cfg_wr_data;
                ffxd_pkg::REG_KEY_COUNT: key_count_reg <= cfg_wr_data[4:0];
                ffxd_pkg::REG_CAPACITY:  capacity_reg  <= cfg_wr_data[15:0];
                default: ;
            endcase
        end
    end

    // input register
    logic               in_valid_reg;
    ffxd_pkg::in_item_t in_item_reg;
    logic               process;

    // result queue
    ffxd_pkg::out_item_t q_mem [QDEPTH];
    logic [QPTR-1:0]     q_wr_reg, q_rd_reg;
    logic [QPTR:0]       q_count_reg;

    assign process = in_valid_reg && (q_count_reg <= (QPTR+1)'(QDEPTH - 2));
    assign s_ready = !in_valid_reg || process;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
    end

    // scan state
    phase_t                 phase_reg, phase_next;
    logic [4:0]             pos_reg, pos_next;
    logic                   mismatch_reg, mismatch_next;
    esc_t                   esc_reg, esc_next;
    logic [3:0]             nibble_reg, nibble_next;
    logic [LENGTH_BITS-1:0] count_reg, count_next;
    logic [1:0]             status_reg, status_next;

    logic [7:0]             b;
    logic [4:0]             hx;
    logic [7:0]             key_ch;
    logic                   klen_ok;
    logic [LENGTH_BITS-1:0] eff_cap;
    logic                   emit_req;
    logic [7:0]             emit_byte;
    logic                   push_data, push_final;
    logic [1:0]             fin_status;
    ffxd_pkg::out_item_t    data_word, final_word;

    assign b       = in_item_reg.body_byte;
    assign hx      = ffxd_pkg::hex_digit_decode(b);
    assign key_ch  = 8'({key_high_reg, key_low_reg} >> {pos_reg[3:0], 3'b000});
    assign klen_ok = (key_count_reg >= 5'd1) && (key_count_reg <= 5'(MAX_KEY_CHARS));
    assign eff_cap = (capacity_reg >= 16'(LEN_LIMIT)) ? LEN_LIMIT
                                                      : LENGTH_BITS'(capacity_reg);

    always_comb begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        mismatch_next = mismatch_reg;
        esc_next      = esc_reg;
        nibble_next   = nibble_reg;
        count_next    = count_reg;
        status_next   = status_reg;
        emit_req      = 1'b0;
        emit_byte     = b;
        push_data     = 1'b0;

        unique case (phase_reg)
            PH_NAME: begin
                if (b == ffxd_pkg::CH_AMP) begin
                    pos_next      = '0;
                    mismatch_next = 1'b0;
                end else if (b == ffxd_pkg::CH_EQUAL) begin
                    if (!mismatch_reg && klen_ok && pos_reg == key_count_reg) begin
                        phase_next  = PH_VALUE;
                        status_next = ffxd_pkg::ST_OK;
                        count_next  = '0;
                        esc_next    = ESC_NONE;
                        if (capacity_reg == 16'd0) begin
                            phase_next  = PH_DONE;
                            status_next = ffxd_pkg::ST_OVERFLOW;
                        end
                    end else begin
                        phase_next = PH_SKIP;
                    end
                end else if (!mismatch_reg && klen_ok && pos_reg < key_count_reg
                             && b == key_ch) begin
                    pos_next = pos_reg + 5'd1;
                end else begin
                    mismatch_next = 1'b1;
                end
            end
            PH_VALUE: begin
                unique case (esc_reg)
                    ESC_HIGH: begin
                        if (!hx[4]) begin
                            phase_next  = PH_DONE;
                            status_next = ffxd_pkg::ST_BAD_ESCAPE;
                            esc_next    = ESC_NONE;
                        end else begin
                            nibble_next = hx[3:0];
                            esc_next    = ESC_LOW;
                        end
                    end
                    ESC_LOW: begin
                        if (!hx[4]) begin
                            phase_next  = PH_DONE;
                            status_next = ffxd_pkg::ST_BAD_ESCAPE;
                        end else begin
                            emit_req  = 1'b1;
                            emit_byte = {nibble_reg, hx[3:0]};
                        end
                        esc_next = ESC_NONE;
                    end
                    default: begin
                        if (b == ffxd_pkg::CH_AMP) begin
                            phase_next = PH_DONE;
                        end else if (b == ffxd_pkg::CH_PERCENT) begin
                            esc_next = ESC_HIGH;
                        end else begin
                            emit_req  = 1'b1;
                            emit_byte = (b == ffxd_pkg::CH_PLUS) ? ffxd_pkg::CH_SPACE : b;
                        end
                    end
                endcase
                if (emit_req) begin
                    if ({1'b0, count_reg} + 1'b1 >= {1'b0, eff_cap}) begin
                        phase_next  = PH_DONE;
                        status_next = ffxd_pkg::ST_OVERFLOW;
                        esc_next    = ESC_NONE;
                    end else begin
                        count_next = count_reg + 1'b1;
                        push_data  = 1'b1;
                    end
                end
            end
            PH_SKIP: begin
                if (b == ffxd_pkg::CH_AMP) begin
                    phase_next    = PH_NAME;
                    pos_next      = '0;
                    mismatch_next = 1'b0;
                end
            end
            default: ;
        endcase
    end

    assign push_final = in_item_reg.body_end;
    assign fin_status = (phase_next == PH_VALUE && esc_next != ESC_NONE)
                        ? ffxd_pkg::ST_BAD_ESCAPE : status_next;

    always_comb begin
        data_word              = '0;
        data_word.data_byte    = emit_byte;
        data_word.data_valid   = 1'b1;
        final_word             = '0;
        final_word.final_flag  = 1'b1;
        final_word.status      = fin_status;
        final_word.value_length = (fin_status == ffxd_pkg::ST_OK) ? 16'(count_next) : 16'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_NAME;
            pos_reg      <= '0;
            mismatch_reg <= 1'b0;
            esc_reg      <= ESC_NONE;
            nibble_reg   <= '0;
            count_reg    <= '0;
            status_reg   <= ffxd_pkg::ST_NOT_FOUND;
        end else if (process) begin
            if (push_final) begin
                // body closed: back to a fresh scan
                phase_reg    <= PH_NAME;
                pos_reg      <= '0;
                mismatch_reg <= 1'b0;
                esc_reg      <= ESC_NONE;
                nibble_reg   <= '0;
                count_reg    <= '0;
                status_reg   <= ffxd_pkg::ST_NOT_FOUND;
            end else begin
                phase_reg    <= phase_next;
                pos_reg      <= pos_next;
                mismatch_reg <= mismatch_next;
                esc_reg      <= esc_next;
                nibble_reg   <= nibble_next;
                count_reg    <= count_next;
                status_reg   <= status_next;
            end
        end
    end

    // queue push / pop
    logic            wr0, wr1;
    logic [QPTR:0]   n_push;
    logic            pop;

    assign wr0    = process && (push_data || push_final);
    assign wr1    = process && push_data && push_final;
    assign n_push = (QPTR+1)'(wr0) + (QPTR+1)'(wr1);
    assign pop    = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (wr0) begin
            q_mem[q_wr_reg] <= push_data ? data_word : final_word;
        end
        if (wr1) begin
            q_mem[q_wr_reg + 1'b1] <= final_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_wr_reg    <= '0;
            q_rd_reg    <= '0;
            q_count_reg <= '0;
        end else begin
            q_wr_reg    <= q_wr_reg + QPTR'(n_push);
            q_rd_reg    <= q_rd_reg + QPTR'(pop);
            q_count_reg <= q_count_reg + n_push - (QPTR+1)'(pop);
        end
    end

    assign m_valid = (q_count_reg != '0);
    assign m_item  = q_mem[q_rd_reg];

endmodule

`default_nettype wire

FILE: rtl/ffxd_checker.sv
// Port-level checks for form_field_extract_decode_top, bound to the top level.
// Depends on ffxd_pkg.
`default_nettype none

module ffxd_port_assertions (
    input wire                      aclk,
    input wire                      aresetn,
    input wire                      m_valid,
    input wire                      m_ready,
    input wire ffxd_pkg::out_item_t m_item
);

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result word shown right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("stalled result word changed");

    a_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_item.data_valid != m_item.final_flag))
        else $error("word is neither data nor closing, or both");

    a_data_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.data_valid |->
            m_item.status == ffxd_pkg::ST_OK && m_item.value_length == 16'd0)
        else $error("data word carries status or length");

    a_err_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.final_flag && m_item.status != ffxd_pkg::ST_OK |->
            m_item.value_length == 16'd0 && m_item.data_byte == 8'd0)
        else $error("failed closing word carries length or data");

endmodule

bind form_field_extract_decode_top ffxd_port_assertions u_ffxd_port_assertions (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

`default_nettype wire
